// ----- hdl/acfp_pkg.sv -----
`default_nettype none

package acfp_pkg;

  // Fixed sizes of the payload fields.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TIMER_W   = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned GAP_W     = 16;
  localparam int unsigned FLAG_W    = 3;

  // Default frame buffer size and the reset value of the idle timeout.
  localparam int unsigned BUFFER_BYTES_DEF = 32;
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 8'd5;

  // Queue between the intake and the frame engine.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pattern lengths and capture positions.
  localparam int unsigned AT_LEN        = 2;
  localparam int unsigned PREFIX_LEN    = 7;
  localparam int unsigned DIGIT_ONE_POS = 7;
  localparam int unsigned DIGIT_TWO_POS = 8;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  // Pattern flag bits.
  localparam int unsigned FLAG_AT  = 0;
  localparam int unsigned FLAG_RUN = 1;
  localparam int unsigned FLAG_GAP = 2;
  localparam logic [FLAG_W-1:0] FLAGS_ALL = 3'b111;

  // Result command codes.
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GAP  = 2'd3;

  // Input item kind codes.
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_TICK = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] rx_byte;
  } at_in_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [RUN_W-1:0] run_value;
    logic [GAP_W-1:0] gap_value;
  } at_out_t;

  typedef struct packed {
    item_kind_t        kind;
    logic [BYTE_W-1:0] data;
  } acfp_item_t;

  // Character expected at a position of "AT".
  function automatic logic [BYTE_W-1:0] at_char(input logic pos);
    logic [BYTE_W-1:0] ch;
    unique case (pos)
      1'b0:    ch = 8'h41; // 'A'
      default: ch = 8'h54; // 'T'
    endcase
    return ch;
  endfunction

  // Character expected at a position of "AT+RUN=".
  function automatic logic [BYTE_W-1:0] run_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h41; // 'A'
      3'd1:    ch = 8'h54; // 'T'
      3'd2:    ch = 8'h2B; // '+'
      3'd3:    ch = 8'h52; // 'R'
      3'd4:    ch = 8'h55; // 'U'
      3'd5:    ch = 8'h4E; // 'N'
      3'd6:    ch = 8'h3D; // '='
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character expected at a position of "AT+GAP=".
  function automatic logic [BYTE_W-1:0] gap_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] ch;
    unique case (pos)
      3'd0:    ch = 8'h41; // 'A'
      3'd1:    ch = 8'h54; // 'T'
      3'd2:    ch = 8'h2B; // '+'
      3'd3:    ch = 8'h47; // 'G'
      3'd4:    ch = 8'h41; // 'A'
      3'd5:    ch = 8'h50; // 'P'
      3'd6:    ch = 8'h3D; // '='
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/acfp_front.sv -----
`default_nettype none

module acfp_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire acfp_pkg::at_in_t    in_data,
  output logic                     q_valid,
  output acfp_pkg::acfp_item_t     q_item,
  input  wire logic                q_pop
);
  import acfp_pkg::*;

  acfp_item_t        queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;
  acfp_item_t        item_in;

  // Sort the request into a byte or a tick before it is queued.
  always_comb begin
    item_in.kind = (in_data.func == FUNC_TICK) ? ITEM_TICK : ITEM_BYTE;
    item_in.data = in_data.rx_byte;
  end

  assign in_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/acfp_back.sv -----
`default_nettype none

module acfp_back #(
  parameter int unsigned BUFFER_BYTES = acfp_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [acfp_pkg::TIMER_W-1:0]  cfg_wdata,
  input  wire logic                          q_valid,
  input  wire acfp_pkg::acfp_item_t          q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output acfp_pkg::at_out_t                  out_data
);
  import acfp_pkg::*;

  localparam int unsigned COUNT_W = $clog2(BUFFER_BYTES + 1);

  logic [TIMER_W-1:0] timeout_ticks;
  logic [TIMER_W-1:0] idle_timer;
  logic [TIMER_W-1:0] idle_timer_next;
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [FLAG_W-1:0]  prefix_flags;
  logic [FLAG_W-1:0]  prefix_flags_next;
  logic [BYTE_W-1:0]  digit_one;
  logic [BYTE_W-1:0]  digit_one_next;
  logic [BYTE_W-1:0]  digit_two;
  logic [BYTE_W-1:0]  digit_two_next;
  logic               close;
  logic [GAP_W-1:0]   d1;
  logic [GAP_W-1:0]   d2;
  at_out_t            result;

  // Take the next request whenever the output register is free or draining.
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // Digits are offset from ASCII zero; wrap-around below zero is intended.
  assign d1 = {{(GAP_W-BYTE_W){1'b0}}, digit_one} - GAP_W'(ASCII_ZERO);
  assign d2 = {{(GAP_W-BYTE_W){1'b0}}, digit_two} - GAP_W'(ASCII_ZERO);

  always_comb begin
    result.command   = CMD_NONE;
    result.run_value = '0;
    result.gap_value = '0;
    priority if (prefix_flags[FLAG_AT] && byte_count == COUNT_W'(AT_LEN)) begin
      result.command = CMD_OK;
    end else if (prefix_flags[FLAG_RUN] && byte_count >= COUNT_W'(PREFIX_LEN)) begin
      result.command   = CMD_RUN;
      result.run_value = d1[RUN_W-1:0];
    end else if (prefix_flags[FLAG_GAP] && byte_count >= COUNT_W'(PREFIX_LEN)) begin
      result.command   = CMD_GAP;
      result.gap_value = (d1 << 3) + (d1 << 1) + d2;
    end
  end

  always_comb begin
    idle_timer_next   = idle_timer;
    byte_count_next   = byte_count;
    prefix_flags_next = prefix_flags;
    digit_one_next    = digit_one;
    digit_two_next    = digit_two;
    close             = 1'b0;
    if (q_pop) begin
      unique case (q_item.kind)
        ITEM_BYTE: begin
          idle_timer_next = timeout_ticks;
          // A full buffer drops the byte but still restarts the idle timer.
          if (byte_count < COUNT_W'(BUFFER_BYTES)) begin
            if (byte_count < COUNT_W'(AT_LEN) && q_item.data != at_char(byte_count[0])) begin
              prefix_flags_next[FLAG_AT] = 1'b0;
            end
            if (byte_count < COUNT_W'(PREFIX_LEN)) begin
              if (q_item.data != run_char(byte_count[2:0])) begin
                prefix_flags_next[FLAG_RUN] = 1'b0;
              end
              if (q_item.data != gap_char(byte_count[2:0])) begin
                prefix_flags_next[FLAG_GAP] = 1'b0;
              end
            end
            if (byte_count == COUNT_W'(DIGIT_ONE_POS)) begin
              digit_one_next = q_item.data;
            end
            if (byte_count == COUNT_W'(DIGIT_TWO_POS)) begin
              digit_two_next = q_item.data;
            end
            byte_count_next = byte_count + COUNT_W'(1);
          end
        end
        default: begin
          // A stopped timer ignores ticks; the last tick closes the frame.
          if (idle_timer != '0) begin
            idle_timer_next = idle_timer - TIMER_W'(1);
            if (idle_timer == TIMER_W'(1)) begin
              close             = 1'b1;
              byte_count_next   = '0;
              prefix_flags_next = FLAGS_ALL;
              digit_one_next    = '0;
              digit_two_next    = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      idle_timer    <= TIMEOUT_RESET;
      byte_count    <= '0;
      prefix_flags  <= FLAGS_ALL;
      digit_one     <= '0;
      digit_two     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
      idle_timer   <= idle_timer_next;
      byte_count   <= byte_count_next;
      prefix_flags <= prefix_flags_next;
      digit_one    <= digit_one_next;
      digit_two    <= digit_two_next;
      if (close) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/at_command_frame_parser.sv -----
`default_nettype none

// AT command frame parser with idle-timeout framing.
//
// Input channel (in_valid, in_stall, in_data): each request is either a
// received UART byte (func = 0, character in rx_byte) or a one millisecond
// tick (func = 1). A request is taken at a clock edge with in_valid high and
// in_stall low. Requests land in a four-entry queue, so in_stall only rises
// when that queue is full.
// Output channel (out_valid, out_stall, out_data): one request is sent each
// time the idle timer runs out on a tick. It carries the command code and
// the run or gap value. While out_valid and out_stall are both high the result
// holds and the frame engine stops draining the queue; the intake keeps filling it.
// Configuration: cfg_we with cfg_wdata sets the idle timeout in ticks.
// The parser takes one request per cycle while in_stall is low. A closing tick
// accepted into an empty queue is written to the queue head; the frame engine
// then pops it, unless a stalled result holds it, and loads the result register
// and out_valid.
// Reset (rst, synchronous) empties the queue, sets the timeout to five ticks
// and loads the idle timer, so five ticks after reset an empty frame closes
// with command none.

module at_command_frame_parser #(
  parameter int unsigned BUFFER_BYTES = acfp_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire acfp_pkg::at_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output acfp_pkg::at_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [acfp_pkg::TIMER_W-1:0]  cfg_wdata
);
  import acfp_pkg::*;

  logic       q_valid;
  logic       q_pop;
  acfp_item_t q_item;

  // Intake: classifies each request and queues it.
  acfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Frame engine: pattern match, digit capture, idle timer and result register.
  acfp_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
